### src/jcfe_pkg.sv
package jcfe_pkg;

    // action codes on the input channel
    localparam logic [1:0] ACT_DATA    = 2'd0;
    localparam logic [1:0] ACT_FINISH  = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    // finish report outcomes
    localparam logic [1:0] OC_COMMANDS = 2'd0;
    localparam logic [1:0] OC_EMPTY    = 2'd1;
    localparam logic [1:0] OC_TEXT     = 2'd2;
    localparam logic [1:0] OC_NO_INPUT = 2'd3;

    // characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [3:0] KEY_LEN = 4'd10;

    typedef enum logic [2:0] {
        ST_SEEK_KEY    = 3'd0,
        ST_SEEK_COLON  = 3'd1,
        ST_SEEK_VALUE  = 3'd2,
        ST_IN_ARRAY    = 3'd3,
        ST_ARRAY_STR   = 3'd4,
        ST_SINGLE_STR  = 3'd5,
        ST_DONE        = 3'd6
    } t_scan_state;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_FINISH  = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    // classified item handed from the front to the back
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       is_ws;
        logic       is_quote;
        logic       is_bslash;
        logic       is_colon;
        logic       is_lbrack;
        logic       is_rbrack;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] outcome;
    } t_result;

    // the quoted key, one character per match position
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = CH_QUOTE;
            4'd1:    c = 8'h63;
            4'd2:    c = 8'h6F;
            4'd3:    c = 8'h6D;
            4'd4:    c = 8'h6D;
            4'd5:    c = 8'h61;
            4'd6:    c = 8'h6E;
            4'd7:    c = 8'h64;
            4'd8:    c = 8'h73;
            4'd9:    c = CH_QUOTE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### src/jcfe_queue.sv
module jcfe_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr_en && !i_rd_en) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr_en && i_rd_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### src/jcfe_front.sv
module jcfe_front
    import jcfe_pkg::*;
(
    input  logic [1:0] i_action,
    input  logic [7:0] i_in_byte,
    output t_item      o_item,
    output logic       o_keep
);

    // unused actions and zero bytes get o_keep low, so they are dropped before the scanner
    always_comb begin
        o_item.data      = i_in_byte;
        o_item.is_ws     = (i_in_byte == CH_SPACE) ||
                           ((i_in_byte >= CH_TAB) && (i_in_byte <= CH_CR));
        o_item.is_quote  = (i_in_byte == CH_QUOTE);
        o_item.is_bslash = (i_in_byte == CH_BSLASH);
        o_item.is_colon  = (i_in_byte == CH_COLON);
        o_item.is_lbrack = (i_in_byte == CH_LBRACK);
        o_item.is_rbrack = (i_in_byte == CH_RBRACK);
        case (i_action)
            ACT_DATA: begin
                o_item.op = OP_BYTE;
                o_keep    = (i_in_byte != 8'h00);
            end
            ACT_FINISH: begin
                o_item.op = OP_FINISH;
                o_keep    = 1'b1;
            end
            ACT_RESTART: begin
                o_item.op = OP_RESTART;
                o_keep    = 1'b1;
            end
            default: begin
                o_item.op = OP_BYTE;
                o_keep    = 1'b0;
            end
        endcase
    end

endmodule

### src/jcfe_back.sv
module jcfe_back
    import jcfe_pkg::*;
#(
    parameter int MAX_DEPTH = 255
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_take,
    input  logic    i_res_full,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    t_scan_state   r_state, n_state;
    logic [3:0]    r_key_cnt, n_key_cnt;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_escape, n_escape;
    logic          r_emitted, n_emitted;
    logic          r_field, n_field;
    logic          r_finished, n_finished;
    logic          r_any_byte, n_any_byte;

    logic          w_take;
    logic          w_live_byte;
    logic          w_in_str;
    logic          w_emit;

    assign w_take      = i_item_valid && !i_res_full;
    assign o_item_take = w_take;
    assign w_live_byte = (i_item.op == OP_BYTE) && !r_finished;
    assign w_in_str    = (r_state == ST_ARRAY_STR) || (r_state == ST_SINGLE_STR);

    // next state
    always_comb begin
        n_state    = r_state;
        n_key_cnt  = r_key_cnt;
        n_depth    = r_depth;
        n_escape   = r_escape;
        n_emitted  = r_emitted;
        n_field    = r_field;
        n_finished = r_finished;
        n_any_byte = r_any_byte;
        case (i_item.op)
            OP_RESTART: begin
                n_state    = ST_SEEK_KEY;
                n_key_cnt  = '0;
                n_depth    = '0;
                n_escape   = 1'b0;
                n_emitted  = 1'b0;
                n_field    = 1'b0;
                n_finished = 1'b0;
                n_any_byte = 1'b0;
            end
            OP_FINISH: begin
                n_finished = 1'b1;
            end
            default: begin
                if (w_live_byte) begin
                    n_any_byte = 1'b1;
                    case (r_state)
                        ST_SEEK_KEY: begin
                            if (i_item.data == key_char(r_key_cnt)) begin
                                if (r_key_cnt == KEY_LEN - 4'd1) begin
                                    n_state   = ST_SEEK_COLON;
                                    n_key_cnt = '0;
                                    n_field   = 1'b1;
                                end else begin
                                    n_key_cnt = r_key_cnt + 4'd1;
                                end
                            end else begin
                                n_key_cnt = {3'b000, i_item.is_quote};
                            end
                        end
                        ST_SEEK_COLON: begin
                            if (i_item.is_colon) begin
                                n_state = ST_SEEK_VALUE;
                            end else if (!i_item.is_ws) begin
                                n_state   = ST_SEEK_KEY;
                                n_key_cnt = '0;
                            end
                        end
                        ST_SEEK_VALUE: begin
                            if (i_item.is_lbrack) begin
                                n_state = ST_IN_ARRAY;
                                n_depth = DW'(1);
                            end else if (i_item.is_quote) begin
                                n_state  = ST_SINGLE_STR;
                                n_escape = 1'b0;
                            end else if (!i_item.is_ws) begin
                                n_state   = ST_SEEK_KEY;
                                n_key_cnt = '0;
                            end
                        end
                        ST_IN_ARRAY: begin
                            if (i_item.is_lbrack) begin
                                if (r_depth < DW'(MAX_DEPTH)) begin
                                    n_depth = r_depth + 1'b1;
                                end
                            end else if (i_item.is_rbrack) begin
                                if (r_depth != '0) begin
                                    n_depth = r_depth - 1'b1;
                                end
                                if (r_depth <= DW'(1)) begin
                                    n_state = ST_DONE;
                                end
                            end else if (r_depth == DW'(1) && i_item.is_quote) begin
                                n_state  = ST_ARRAY_STR;
                                n_escape = 1'b0;
                            end
                        end
                        ST_ARRAY_STR, ST_SINGLE_STR: begin
                            if (r_escape) begin
                                n_escape = 1'b0;
                            end else if (i_item.is_bslash) begin
                                n_escape = 1'b1;
                            end else if (i_item.is_quote) begin
                                n_emitted = 1'b1;
                                n_state   = (r_state == ST_ARRAY_STR) ? ST_IN_ARRAY
                                                                      : ST_DONE;
                            end
                        end
                        default: begin
                            n_state = r_state;
                        end
                    endcase
                end
            end
        endcase
    end

    // result
    always_comb begin
        w_emit        = 1'b0;
        o_res.kind    = KIND_BYTE;
        o_res.data    = 8'h00;
        o_res.outcome = OC_COMMANDS;
        case (i_item.op)
            OP_FINISH: begin
                w_emit     = !r_finished;
                o_res.kind = KIND_REPORT;
                if (r_emitted) begin
                    o_res.outcome = OC_COMMANDS;
                end else if (r_field) begin
                    o_res.outcome = OC_EMPTY;
                end else if (r_any_byte) begin
                    o_res.outcome = OC_TEXT;
                end else begin
                    o_res.outcome = OC_NO_INPUT;
                end
            end
            OP_BYTE: begin
                if (w_live_byte && w_in_str) begin
                    if (r_escape) begin
                        w_emit     = 1'b1;
                        o_res.data = i_item.data;
                    end else if (i_item.is_quote) begin
                        w_emit     = 1'b1;
                        o_res.kind = KIND_END;
                    end else if (!i_item.is_bslash) begin
                        w_emit     = 1'b1;
                        o_res.data = i_item.data;
                    end
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    assign o_res_valid = w_take && w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_SEEK_KEY;
            r_key_cnt  <= '0;
            r_depth    <= '0;
            r_escape   <= 1'b0;
            r_emitted  <= 1'b0;
            r_field    <= 1'b0;
            r_finished <= 1'b0;
            r_any_byte <= 1'b0;
        end else if (w_take) begin
            r_state    <= n_state;
            r_key_cnt  <= n_key_cnt;
            r_depth    <= n_depth;
            r_escape   <= n_escape;
            r_emitted  <= n_emitted;
            r_field    <= n_field;
            r_finished <= n_finished;
            r_any_byte <= n_any_byte;
        end
    end

endmodule

### src/json_command_field_extractor.sv
// channel   | handshake        | payload
// ----------+------------------+---------------------------------
// input     | push / full      | i_action, i_in_byte
// result    | empty / pop      | o_kind, o_out_byte, o_outcome
//
// one item is taken every cycle unless the command queue is empty or the result queue is full;
// the scanner updates its state per item, and a result is registered in the result queue before the ports
// a full result queue stalls the scanner, which lets the command queue fill
// synchronous active-low reset empties both queues and returns to key search
module json_command_field_extractor
    import jcfe_pkg::*;
#(
    parameter int MAX_DEPTH = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_action,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_outcome
);

    // short queue between classifier and scanner
    localparam int CMD_DEPTH = 4;
    // output queue, two entries keep one result per cycle flowing while results are popped
    localparam int RES_DEPTH = 2;

    t_item   w_front_item;
    logic    w_keep;
    logic    w_cmd_wr;
    logic [$bits(t_item)-1:0] w_cmd_rd_data;
    logic    w_cmd_empty;
    logic    w_cmd_take;
    t_item   w_back_item;

    logic    w_res_valid;
    t_result w_res;
    logic    w_res_full;
    logic [$bits(t_result)-1:0] w_res_rd_data;
    t_result w_out;

    // front: decode action and classify the byte
    jcfe_front u_front (
        .i_action  (i_action),
        .i_in_byte (i_in_byte),
        .o_item    (w_front_item),
        .o_keep    (w_keep)
    );

    // items with o_keep low (unused actions, zero bytes) are taken and dropped here
    assign w_cmd_wr = push && !full && w_keep;

    jcfe_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_cmd_wr),
        .i_wr_data (w_front_item),
        .i_rd_en   (w_cmd_take),
        .o_rd_data (w_cmd_rd_data),
        .o_empty   (w_cmd_empty),
        .o_full    (full)
    );

    assign w_back_item = t_item'(w_cmd_rd_data);

    // back: key match, value tracking and string capture
    jcfe_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!w_cmd_empty),
        .i_item       (w_back_item),
        .o_item_take  (w_cmd_take),
        .i_res_full   (w_res_full),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    jcfe_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_res_valid),
        .i_wr_data (w_res),
        .i_rd_en   (pop && !empty),
        .o_rd_data (w_res_rd_data),
        .o_empty   (empty),
        .o_full    (w_res_full)
    );

    assign w_out      = t_result'(w_res_rd_data);
    assign o_kind     = w_out.kind;
    assign o_out_byte = w_out.data;
    assign o_outcome  = w_out.outcome;

endmodule
